>>> rtl/core/adsr_pkg.sv
// Shared types, constants and helper functions of the ADSR envelope generator.
package adsr_pkg;

   // Level format: unsigned fixed point, 1.0 is 2^LEVEL_FRAC_BITS
   localparam int LEVEL_FRAC_BITS = 30;
   localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
   localparam int OUT_FRAC_BITS   = 24;
   localparam int SUS_SHIFT       = LEVEL_FRAC_BITS - OUT_FRAC_BITS;
   localparam int ENV_W           = OUT_FRAC_BITS + 1;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

   // Register widths
   localparam int SAMPLES_W   = 24;
   localparam int COUNT_WIDTH = 24;
   localparam int SUSTAIN_W   = 25;
   localparam int DEBOUNCE_W  = 16;
   localparam int DCOUNT_W    = 17;
   localparam logic [SUSTAIN_W-1:0] SUSTAIN_FULL = {1'b1, {OUT_FRAC_BITS{1'b0}}};
   localparam logic [DCOUNT_W-1:0]  DCOUNT_MAX   = {DCOUNT_W{1'b1}};

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUSTAIN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIXED    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 3'd5;

   // Serial divider: one quotient bit per cycle over the full level width
   localparam int DIV_STEPS = LEVEL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      PH_OFF      = 3'd0,
      PH_ATTACK   = 3'd1,
      PH_DECAY    = 3'd2,
      PH_SUSTAIN  = 3'd3,
      PH_REL_DEB  = 3'd4,
      PH_RELEASE  = 3'd5,
      PH_HELD     = 3'd6,
      PH_OFF_DEB  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [LEVEL_W-1:0]   dividend;
      logic [COUNT_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [LEVEL_W-1:0]   quotient;
   } div_rsp_type;

   // Mask a sample count to the counter width; zero counts as one
   function automatic logic [COUNT_WIDTH-1:0] fix_count(input logic [SAMPLES_W-1:0] samples);
      logic [COUNT_WIDTH-1:0] n;
      n = samples[COUNT_WIDTH-1:0];
      if (n == '0) begin
         n = COUNT_WIDTH'(1);
      end
      return n;
   endfunction

   // Saturating debounce counter increment
   function automatic logic [DCOUNT_W-1:0] count_up(input logic [DCOUNT_W-1:0] count);
      return (count < DCOUNT_MAX) ? count + DCOUNT_W'(1) : count;
   endfunction

endpackage

>>> rtl/core/adsr_if.sv
// Channel interfaces of the ADSR envelope generator: request, response, register write.
interface adsr_req_if;
   logic valid;
   logic ready;
   logic note_on;

   modport source (output valid, output note_on, input ready);
   modport sink   (input valid, input note_on, output ready);
endinterface

interface adsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [24:0] env_level;
   logic [2:0]  phase_code;

   modport source (output valid, output env_level, output phase_code, input ready);
   modport sink   (input valid, input env_level, input phase_code, output ready);
endinterface

interface adsr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [24:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> rtl/core/adsr_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module adsr_divider
   import adsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]     quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] dvs_ff, dvs_in;
   logic [COUNT_WIDTH:0]   trial;
   logic                   fits;

   // Shift the next dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, quo_ff[LEVEL_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[LEVEL_W-2:0], fits};
         rem_in = fits ? COUNT_WIDTH'(trial - {1'b0, dvs_ff}) : trial[COUNT_WIDTH-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

>>> rtl/core/adsr_envelope_generator.sv
// ADSR envelope generator top level: phase control, level update, registers.
//
//   channel   dir  payload                         accepted when
//   req_chan  in   note_on                         valid && ready
//   rsp_chan  out  env_level[24:0], phase_code[2:0] valid && ready
//   csr_chan  in   reg_index[2:0], wr_data[24:0]   valid && ready (always ready)
//
// A request that starts a ramp (attack, decay or release entry) passes through the
// divide step: the step is found by a serial divider that yields one quotient bit per
// cycle over the 31-bit level. Any other request goes straight to the final step.
// One request is in work at a time; the next is taken while the previous response
// still waits in the output register. A stalled response holds the block in its
// final step. Reset is synchronous and restores the register defaults.
module adsr_envelope_generator
   import adsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   adsr_req_if.sink     req_chan,
   adsr_rsp_if.source   rsp_chan,
   adsr_csr_if.sink     csr_chan
);

   // Configuration registers
   logic [SAMPLES_W-1:0]  attack_ff;
   logic [SAMPLES_W-1:0]  decay_ff;
   logic [SAMPLES_W-1:0]  release_ff;
   logic [SUSTAIN_W-1:0]  sustain_ff;
   logic                  fixed_ff;
   logic [DEBOUNCE_W-1:0] debounce_ff;

   // Envelope state
   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [LEVEL_W-1:0]    step_mag_ff, step_mag_in;
   logic                  step_neg_ff, step_neg_in;
   logic [DCOUNT_W-1:0]   count_ff, count_in;
   logic                  add_ff, add_in;
   logic                  div_neg_ff, div_neg_in;
   logic                  mag_nz_ff, mag_nz_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ENV_W-1:0]      rsp_level_ff, rsp_level_in;
   phase_type             rsp_phase_ff, rsp_phase_in;

   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic                  req_fire;
   logic                  out_free;
   logic [SUSTAIN_W-1:0]  sus_clip;
   logic [LEVEL_W-1:0]    sus_target;
   logic                  lvl_full, lvl_zero, lvl_le_sus, cnt_over;
   logic [LEVEL_W-1:0]    new_mag;
   logic [LEVEL_W-1:0]    added;
   logic [LEVEL_W:0]      sum;

   // Register writes; unknown indexes are dropped
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff   <= SAMPLES_W'(441);
         decay_ff    <= SAMPLES_W'(441);
         release_ff  <= SAMPLES_W'(441);
         sustain_ff  <= SUSTAIN_W'(8388608);
         fixed_ff    <= 1'b0;
         debounce_ff <= DEBOUNCE_W'(882);
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CSR_ATTACK:   attack_ff   <= csr_chan.wr_data[SAMPLES_W-1:0];
            CSR_DECAY:    decay_ff    <= csr_chan.wr_data[SAMPLES_W-1:0];
            CSR_RELEASE:  release_ff  <= csr_chan.wr_data[SAMPLES_W-1:0];
            CSR_SUSTAIN:  sustain_ff  <= csr_chan.wr_data[SUSTAIN_W-1:0];
            CSR_FIXED:    fixed_ff    <= csr_chan.wr_data[0];
            CSR_DEBOUNCE: debounce_ff <= csr_chan.wr_data[DEBOUNCE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sustain target in level format: zero in fixed mode, clipped to full scale
   assign sus_clip   = (sustain_ff > SUSTAIN_FULL) ? SUSTAIN_FULL : sustain_ff;
   assign sus_target = fixed_ff ? '0 : {sus_clip, {SUS_SHIFT{1'b0}}};

   assign lvl_full   = level_ff >= LEVEL_ONE;
   assign lvl_zero   = level_ff == '0;
   assign lvl_le_sus = level_ff <= sus_target;
   assign cnt_over   = count_ff > {1'b0, debounce_ff};

   assign req_chan.ready = state_ff == ST_IDLE;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Step magnitude from the quotient, at least one LSB for a nonzero difference
   assign new_mag = (div_rsp.quotient == '0 && mag_nz_ff) ? LEVEL_W'(1) : div_rsp.quotient;

   // Saturating level update
   assign sum = {1'b0, level_ff} + {1'b0, step_mag_ff};
   always_comb begin
      if (step_neg_ff) begin
         added = (level_ff < step_mag_ff) ? '0 : level_ff - step_mag_ff;
      end else begin
         added = (sum > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : sum[LEVEL_W-1:0];
      end
   end

   // Sequencer: evaluate phase on request, divide if a ramp starts, then add the step if the phase ramps, and respond
   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      level_in         = level_ff;
      step_mag_in      = step_mag_ff;
      step_neg_in      = step_neg_ff;
      count_in         = count_ff;
      add_in           = add_ff;
      div_neg_in       = div_neg_ff;
      mag_nz_in        = mag_nz_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_level_in     = rsp_level_ff;
      rsp_phase_in     = rsp_phase_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = fix_count(attack_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               add_in = 1'b0;
               unique case (phase_ff)
                  PH_OFF: begin
                     if (req_chan.note_on) begin
                        phase_in         = PH_ATTACK;
                        div_req.start    = 1'b1;
                        div_req.dividend = LEVEL_ONE - level_ff;
                        div_neg_in       = 1'b0;
                     end
                  end
                  PH_ATTACK: begin
                     add_in = 1'b1;
                     if (lvl_full) begin
                        level_in         = LEVEL_ONE;
                        phase_in         = PH_DECAY;
                        div_req.start    = 1'b1;
                        div_req.dividend = LEVEL_ONE - sus_target;
                        div_req.divisor  = fix_count(decay_ff);
                        div_neg_in       = 1'b1;
                     end
                  end
                  PH_DECAY: begin
                     add_in = 1'b1;
                     if (lvl_le_sus) begin
                        if (fixed_ff && req_chan.note_on) begin
                           phase_in = PH_HELD;
                        end else if (fixed_ff) begin
                           phase_in = PH_OFF_DEB;
                           count_in = '0;
                        end else begin
                           phase_in = PH_SUSTAIN;
                        end
                     end
                  end
                  PH_SUSTAIN: begin
                     if (!req_chan.note_on) begin
                        phase_in         = PH_REL_DEB;
                        count_in         = '0;
                        div_req.start    = 1'b1;
                        div_req.dividend = level_ff;
                        div_req.divisor  = fix_count(release_ff);
                        div_neg_in       = 1'b1;
                     end
                  end
                  PH_REL_DEB: begin
                     add_in   = 1'b1;
                     count_in = count_up(count_ff);
                     if (lvl_zero) begin
                        phase_in = PH_OFF;
                     end else if (cnt_over) begin
                        phase_in = PH_RELEASE;
                     end
                  end
                  PH_RELEASE: begin
                     add_in = 1'b1;
                     if (req_chan.note_on) begin
                        phase_in         = PH_ATTACK;
                        div_req.start    = 1'b1;
                        div_req.dividend = LEVEL_ONE - level_ff;
                        div_neg_in       = 1'b0;
                     end else if (lvl_zero) begin
                        phase_in = PH_OFF;
                     end
                  end
                  PH_HELD: begin
                     if (!req_chan.note_on) begin
                        phase_in = PH_OFF_DEB;
                        count_in = '0;
                     end
                  end
                  PH_OFF_DEB: begin
                     count_in = count_up(count_ff);
                     if (cnt_over) begin
                        phase_in = PH_OFF;
                     end
                  end
               endcase
               mag_nz_in = div_req.dividend != '0;
               state_in  = div_req.start ? ST_DIVIDE : ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               step_mag_in = new_mag;
               step_neg_in = div_neg_ff;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               level_in     = add_ff ? added : level_ff;
               rsp_valid_in = 1'b1;
               rsp_level_in = level_in[LEVEL_W-1:SUS_SHIFT];
               rsp_phase_in = phase_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_OFF;
         level_ff     <= '0;
         step_mag_ff  <= '0;
         step_neg_ff  <= 1'b0;
         count_ff     <= '0;
         add_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         step_mag_ff  <= step_mag_in;
         step_neg_ff  <= step_neg_in;
         count_ff     <= count_in;
         add_ff       <= add_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_neg_ff   <= div_neg_in;
      mag_nz_ff    <= mag_nz_in;
      rsp_level_ff <= rsp_level_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   adsr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.env_level  = rsp_level_ff;
   assign rsp_chan.phase_code = rsp_phase_ff;

`ifndef SYNTH
   // Level stays within full scale
   assert property (@(posedge clock) disable iff (reset) level_ff <= LEVEL_ONE)
      else $error("envelope level above full scale");

   // Divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) div_rsp.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide step");

   // A taken request blocks the next one until it is done
   assert property (@(posedge clock) disable iff (reset) req_fire |=> !req_chan.ready)
      else $error("request taken while another is in work");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench of the ADSR envelope generator: per-tick level and phase checked against a predictor.

module tb;
   import adsr_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int SEGMENTS       = 12;
   localparam int SEGMENT_ITEMS  = 152;
   localparam int SETTLE_CYCLES  = 48;
   localparam int SQUEEZE_CYCLES = 320;
   localparam int STALL_LIMIT    = 4000;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [SUSTAIN_W-1:0]   SUSTAIN_TOP  = '1;
   localparam longint                 LEVEL_FULL   = longint'(1) << LEVEL_FRAC_BITS;

   // note_on patterns of the directed part, first tick at the left
   localparam logic [0:10] PRESS_PLAIN = 11'b1111_0000000;
   localparam logic [0:10] PRESS_FIXED = 11'b111111_00001;

   typedef struct packed {
      logic [ENV_W-1:0] env_level;
      logic [2:0]       phase_code;
   } env_tick_type;

   // Envelope predictor and store of expected ticks
   class envelope_scoreboard;
      logic [SAMPLES_W-1:0]  attack_len;
      logic [SAMPLES_W-1:0]  decay_len;
      logic [SAMPLES_W-1:0]  release_len;
      logic [SUSTAIN_W-1:0]  sustain_lvl;
      logic                  fixed_mode;
      logic [DEBOUNCE_W-1:0] debounce_len;
      phase_type             phase;
      longint                level;
      longint                step;
      int unsigned           debounce_cnt;
      env_tick_type          ticks_due[$];
      int unsigned           requests;
      int unsigned           responses;
      int unsigned           errors;
      logic [7:0]            phases_seen;

      function new();
         attack_len   = SAMPLES_W'(441);
         decay_len    = SAMPLES_W'(441);
         release_len  = SAMPLES_W'(441);
         sustain_lvl  = SUSTAIN_W'(8388608);
         fixed_mode   = 1'b0;
         debounce_len = DEBOUNCE_W'(882);
         phase        = PH_OFF;
         level        = 0;
         step         = 0;
         debounce_cnt = 0;
         requests     = 0;
         responses    = 0;
         errors       = 0;
         phases_seen  = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ATTACK:   attack_len   = data[SAMPLES_W-1:0];
            CSR_DECAY:    decay_len    = data[SAMPLES_W-1:0];
            CSR_RELEASE:  release_len  = data[SAMPLES_W-1:0];
            CSR_SUSTAIN:  sustain_lvl  = data[SUSTAIN_W-1:0];
            CSR_FIXED:    fixed_mode   = data[0];
            CSR_DEBOUNCE: debounce_len = data[DEBOUNCE_W-1:0];
            default: ;
         endcase
      endfunction

      // Step toward target over the masked sample count, at least one LSB if not there yet
      function longint ramp_to(longint target, logic [SAMPLES_W-1:0] samples);
         longint diff;
         longint mag;
         longint quo;
         longint n;
         diff = target - level;
         n = longint'(samples[COUNT_WIDTH-1:0]);
         if (n == 0) begin
            n = 1;
         end
         mag = (diff < 0) ? -diff : diff;
         quo = mag / n;
         if (mag != 0 && quo == 0) begin
            quo = 1;
         end
         return (diff < 0) ? -quo : quo;
      endfunction

      function longint sustain_goal();
         longint s;
         if (fixed_mode) begin
            return 0;
         end
         s = longint'(sustain_lvl);
         if (s > longint'(SUSTAIN_FULL)) begin
            s = longint'(SUSTAIN_FULL);
         end
         return s << SUS_SHIFT;
      endfunction

      // Add the step and clamp the level to [0, 1.0]
      function void apply_step();
         level = level + step;
         if (level < 0) begin
            level = 0;
         end
         if (level > LEVEL_FULL) begin
            level = LEVEL_FULL;
         end
      endfunction

      function void bump_debounce();
         if (debounce_cnt < DCOUNT_MAX) begin
            debounce_cnt++;
         end
      endfunction

      // Advance one sample tick and queue the expected level and phase
      function void note_request(logic note_on);
         longint       sus;
         env_tick_type tick;
         sus = sustain_goal();
         case (phase)
            PH_OFF: begin
               if (note_on) begin
                  phase = PH_ATTACK;
                  step  = ramp_to(LEVEL_FULL, attack_len);
               end
            end
            PH_ATTACK: begin
               if (level >= LEVEL_FULL) begin
                  level = LEVEL_FULL;
                  phase = PH_DECAY;
                  step  = ramp_to(sus, decay_len);
               end
               apply_step();
            end
            PH_DECAY: begin
               if (level <= sus) begin
                  if (fixed_mode && note_on) begin
                     phase = PH_HELD;
                  end else if (fixed_mode) begin
                     phase        = PH_OFF_DEB;
                     debounce_cnt = 0;
                  end else begin
                     phase = PH_SUSTAIN;
                  end
               end
               apply_step();
            end
            PH_SUSTAIN: begin
               if (!note_on) begin
                  phase        = PH_REL_DEB;
                  debounce_cnt = 0;
                  step         = ramp_to(0, release_len);
               end
            end
            PH_REL_DEB: begin
               if (debounce_cnt > debounce_len) begin
                  phase = PH_RELEASE;
               end
               if (level <= 0) begin
                  level = 0;
                  phase = PH_OFF;
               end
               apply_step();
               bump_debounce();
            end
            PH_RELEASE: begin
               if (level <= 0) begin
                  level = 0;
                  phase = PH_OFF;
               end
               if (note_on) begin
                  phase = PH_ATTACK;
                  step  = ramp_to(LEVEL_FULL, attack_len);
               end
               apply_step();
            end
            PH_HELD: begin
               if (!note_on) begin
                  phase        = PH_OFF_DEB;
                  debounce_cnt = 0;
               end
            end
            default: begin
               if (debounce_cnt > debounce_len) begin
                  phase = PH_OFF;
               end
               bump_debounce();
            end
         endcase
         tick.env_level  = ENV_W'(level >>> SUS_SHIFT);
         tick.phase_code = phase;
         ticks_due.push_back(tick);
         phases_seen[phase] = 1'b1;
         requests++;
      endfunction

      function void check_response(logic [ENV_W-1:0] env_level, logic [2:0] phase_code);
         env_tick_type want;
         responses++;
         if (ticks_due.size() == 0) begin
            errors++;
            $error("response with no request waiting: env_level %0d, phase_code %0d",
                   env_level, phase_code);
            return;
         end
         want = ticks_due.pop_front();
         if (env_level !== want.env_level) begin
            errors++;
            $error("env_level: expected %0d, actual %0d", want.env_level, env_level);
         end
         if (phase_code !== want.phase_code) begin
            errors++;
            $error("phase_code: expected %0d, actual %0d", want.phase_code, phase_code);
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   adsr_req_if req_bus ();
   adsr_rsp_if rsp_bus ();
   adsr_csr_if csr_bus ();

   adsr_envelope_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   envelope_scoreboard sb = new();

   bit          squeeze_go;
   bit          gaps_on;
   int unsigned burst_left;
   int unsigned settings_done;
   int unsigned hold_left;
   int unsigned rest_left;
   int unsigned noise_pct;
   int unsigned press_max;
   int unsigned rest_max;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // End the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb: errors");
            $finish;
         end
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_response(rsp_bus.env_level, rsp_bus.phase_code);
      end
   end

   // Stall responses on a pattern whose mode is redrawn at random
   initial begin
      int unsigned rx_left;
      int unsigned rx_mode;
      int unsigned rx_tick;
      rx_left = 0;
      rx_mode = 0;
      rx_tick = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze_go) begin
            // hold off long enough for the block to back up into its input
            squeeze_go = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else begin
            if (rx_left == 0) begin
               rx_mode = $urandom_range(0, 4);
               rx_left = $urandom_range(10, 150);
            end
            rx_left--;
            case (rx_mode)
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= (rx_tick % 3 == 0);
               3: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= 1'b1;
            endcase
            rx_tick++;
            @(posedge clock);
         end
      end
   end

   task automatic send_note(input logic note_on);
      req_bus.valid   <= 1'b1;
      req_bus.note_on <= note_on;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(note_on);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop requests, wait for every response, then let a pending divide finish
   task automatic drain();
      pause_sender(1);
      while (sb.ticks_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wr_data   <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(index, data);
   endtask

   // Write all registers plus the two unused indexes
   task automatic configure(input logic [CSR_DATA_W-1:0] attack_data,
                            input logic [CSR_DATA_W-1:0] decay_data,
                            input logic [CSR_DATA_W-1:0] rel_data,
                            input logic [CSR_DATA_W-1:0] sustain_data,
                            input logic [CSR_DATA_W-1:0] fixed_data,
                            input logic [CSR_DATA_W-1:0] debounce_data);
      write_csr(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      write_csr(CSR_ATTACK, attack_data);
      write_csr(CSR_DECAY, decay_data);
      write_csr(CSR_RELEASE, rel_data);
      write_csr(CSR_SUSTAIN, sustain_data);
      write_csr(CSR_FIXED, fixed_data);
      write_csr(CSR_DEBOUNCE, debounce_data);
      write_csr(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      settings_done++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_count(input bit extreme);
      logic [CSR_DATA_W-1:0] v;
      if (extreme) begin
         case ($urandom_range(0, 3))
            0: v = '0;
            1: v = CSR_DATA_W'(24'hFFFFFF);
            2: v = CSR_DATA_W'(1);
            default: v = CSR_DATA_W'($urandom);
         endcase
      end else begin
         v = CSR_DATA_W'($urandom_range(0, 24));
      end
      // bit 24 lies above the counter and must be ignored
      v[24] = 1'($urandom_range(0, 1));
      return v;
   endfunction

   function automatic int unsigned clamp_span(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
      if (v < lo) begin
         return lo;
      end
      return (v > hi) ? hi : v;
   endfunction

   // Draw a register setting and size the press pattern to its ramp lengths
   task automatic pick_settings(input bit extreme);
      logic [CSR_DATA_W-1:0] sus;
      logic [CSR_DATA_W-1:0] deb;
      case ($urandom_range(0, 4))
         0: sus = '0;
         1: sus = CSR_DATA_W'(SUSTAIN_FULL);
         2: sus = CSR_DATA_W'($urandom_range(SUSTAIN_FULL + 1, SUSTAIN_TOP));
         default: sus = CSR_DATA_W'($urandom_range(0, SUSTAIN_FULL));
      endcase
      deb = CSR_DATA_W'($urandom);
      if (extreme) begin
         case ($urandom_range(0, 2))
            0: deb[DEBOUNCE_W-1:0] = '0;
            1: deb[DEBOUNCE_W-1:0] = '1;
            default: ;
         endcase
      end else begin
         deb[DEBOUNCE_W-1:0] = DEBOUNCE_W'($urandom_range(0, 12));
      end
      configure(pick_count(extreme), pick_count(extreme), pick_count(extreme), sus,
                CSR_DATA_W'($urandom), deb);
      press_max = clamp_span(sb.attack_len + sb.decay_len + 12, 6, 90);
      rest_max  = clamp_span(sb.release_len + sb.debounce_len + 12, 4, 90);
   endtask

   // Mostly press-and-release runs, with some random ticks mixed in
   function automatic logic next_note();
      if ($urandom_range(0, 99) < noise_pct) begin
         return 1'($urandom_range(0, 1));
      end
      if (hold_left == 0 && rest_left == 0) begin
         hold_left = $urandom_range(1, press_max);
         rest_left = $urandom_range(0, rest_max);
      end
      if (hold_left != 0) begin
         hold_left--;
         return 1'b1;
      end
      rest_left--;
      return 1'b0;
   endfunction

   task automatic run_segment(input int unsigned items, input bit squeeze, input bit mid_drain);
      int unsigned i;
      for (i = 0; i < items; i++) begin
         if (squeeze && i == 4) begin
            squeeze_go = 1'b1;
         end
         if (mid_drain && i == items / 2) begin
            drain();
         end
         send_note(next_note());
         if (burst_left > 0) begin
            burst_left--;
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            if (gaps_on) begin
               pause_sender($urandom_range(1, 14));
            end
         end
      end
   endtask

   initial begin
      int unsigned seg;
      int unsigned k;
      req_bus.valid     <= 1'b0;
      req_bus.note_on   <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.reg_index <= CSR_ATTACK;
      csr_bus.wr_data   <= '0;
      squeeze_go    = 1'b0;
      gaps_on       = 1'b0;
      burst_left    = 0;
      settings_done = 0;
      hold_left     = 0;
      rest_left     = 0;
      noise_pct     = 0;
      press_max     = 6;
      rest_max      = 4;
      idle_cycles   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero and one counts, a count with only bit 24 set, sustain above full scale, no debounce
      configure('0, CSR_DATA_W'(1), {1'b1, 24'h0}, SUSTAIN_TOP, 25'h1FFFFFE, '0);
      for (k = 0; k < 11; k++) begin
         send_note(PRESS_PLAIN[k]);
      end
      drain();

      // fixed-duration run through held and off debounce
      configure(25'h1000001, CSR_DATA_W'(2), CSR_DATA_W'(1), '0, CSR_DATA_W'(1),
                CSR_DATA_W'(2));
      for (k = 0; k < 11; k++) begin
         send_note(PRESS_FIXED[k]);
      end
      drain();

      // random settings, one segment each
      for (seg = 0; seg < SEGMENTS; seg++) begin
         pick_settings(seg % 4 == 3);
         noise_pct  = (seg % 5 == 0) ? 0 : $urandom_range(2, 20);
         gaps_on    = (seg % 3 != 1);
         burst_left = $urandom_range(1, 48);
         hold_left  = 0;
         rest_left  = 0;
         run_segment(SEGMENT_ITEMS, seg == 5, seg == 8);
         drain();
      end

      $display("summary: %0d requests, %0d responses checked under %0d register settings",
               sb.requests, sb.responses, settings_done);
      $display("summary: phase codes reached (bit per code) %b", sb.phases_seen);
      if (sb.errors == 0 && sb.ticks_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

>>> adsr_envelope_generator.f
rtl/core/adsr_pkg.sv
rtl/core/adsr_if.sv
rtl/core/adsr_divider.sv
rtl/core/adsr_envelope_generator.sv
dv/tb.sv
